// ===== rtl/core/access_code_enroll_and_check_macros.svh =====
// Assertion macros shared by the access code block.
// Each macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ACCESS_CODE_ENROLL_AND_CHECK_MACROS_SVH
`define ACCESS_CODE_ENROLL_AND_CHECK_MACROS_SVH

// The condition holds at every clock edge.
`define ACEC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ACEC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ACEC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/acec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acec_pkg;

	// Character that ends a line.
	localparam logic [7:0] CHAR_NL = 8'd10;

	// Operating modes.
	localparam logic [1:0] MODE_ENROLL  = 2'd0;
	localparam logic [1:0] MODE_CHECK   = 2'd1;
	localparam logic [1:0] MODE_STOPPED = 2'd2;

	// Status codes of a result.
	localparam logic [2:0] ST_ENROLLED     = 3'd0;
	localparam logic [2:0] ST_NOT_HEX      = 3'd1;
	localparam logic [2:0] ST_WRONG_LENGTH = 3'd2;
	localparam logic [2:0] ST_DUPLICATE    = 3'd3;
	localparam logic [2:0] ST_ENROLL_CLOSED = 3'd4;
	localparam logic [2:0] ST_OPEN         = 3'd5;
	localparam logic [2:0] ST_WRONG_CODE   = 3'd6;
	localparam logic [2:0] ST_STOPPED      = 3'd7;

	// True for 0-9, a-f and A-F.
	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acec_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module acec_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/access_code_enroll_and_check.sv =====
// Timing: a character gives no result; a newline that needs no table search gives its result
// in the cycle after it is taken, a searching newline once the search finds a match or has read
// every code stored before the line (one table entry per cycle through the code RAM read port,
// then the registered read, the stage-one compare and the result register).
// Throughput: one character per cycle, stalled by a search or, for a newline, a full result register.
// Reset clears the mode, line state, code count and handshake state; the code RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module access_code_enroll_and_check #(
	parameter int TABLE_SLOTS = 32,
	parameter int CODE_CHARS  = 8,
	parameter int LINE_MAX    = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       ch_valid,
	output logic            ch_ready,
	input  wire logic [7:0] ch,

	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [2:0]      status,
	output logic [4:0]      matched_slot,
	output logic [4:0]      stored_count
);

	`include "access_code_enroll_and_check_macros.svh"

	// Widths of the code count, the line length and one stored code.
	localparam int CW = $clog2(TABLE_SLOTS);
	localparam int LW = $clog2(LINE_MAX);
	localparam int DW = 8 * CODE_CHARS;

	localparam logic [CW-1:0] COUNT_FULL = CW'(TABLE_SLOTS - 1);
	localparam logic [LW-1:0] CODE_LEN   = LW'(CODE_CHARS);
	localparam logic [LW-1:0] LEN_SAT    = LW'(LINE_MAX - 1);

	// Controller states: taking characters, or searching the code table.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic          state_q;
	logic [1:0]    mode_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] line_len_q;
	logic          all_hex_q;
	logic [7:0]    line_chars_q [CODE_CHARS];
	logic [DW-1:0] line_word;

	// Search pipeline: the address stage issues one read per cycle, and stage one
	// compares the registered RAM data with the line.
	logic [CW-1:0] idx_q;
	logic          issue_q;
	logic          rd_valid_s1;
	logic [CW-1:0] rd_idx_s1;
	logic          rd_last_s1;
	logic [DW-1:0] rdata;
	logic [CW-1:0] last_idx;

	logic          res_valid_q;
	logic [2:0]    status_q;
	logic [4:0]    slot_q;
	logic [4:0]    stored_q;

	logic          ch_is_nl;
	logic          ch_acc;
	logic          nl_acc;
	logic          char_acc;
	logic          line_full;

	// Decision taken when a newline is accepted.
	logic          start_scan;
	logic          dir_store;
	logic [2:0]    dir_status;
	logic [1:0]    mode_next;

	logic          scan_hit;
	logic          scan_miss;
	logic          finish;
	logic [2:0]    fin_status;
	logic [CW-1:0] fin_slot;

	logic          mem_we;
	logic          res_load;
	logic [2:0]    res_status;
	logic [CW-1:0] res_slot;
	logic [CW-1:0] count_next;
	logic [CW+4:0] slot_ext;
	logic [CW+4:0] count_ext;

	assign ch_is_nl  = (ch == acec_pkg::CHAR_NL);
	// A newline needs the result register free, or being emptied in this cycle.
	assign ch_ready  = (state_q == ST_IDLE) && (!ch_is_nl || !res_valid_q || res_ready);
	assign ch_acc    = ch_valid && ch_ready;
	assign nl_acc    = ch_acc && ch_is_nl;
	assign char_acc  = ch_acc && !ch_is_nl;
	assign line_full = (line_len_q == CODE_LEN);
	assign last_idx  = count_q - CW'(1);

	// Character i of the line sits in bits 8i and up of the packed code.
	always_comb begin
		for (int i = 0; i < CODE_CHARS; i++) begin
			line_word[8*i +: 8] = line_chars_q[i];
		end
	end

	// Classify a line at its newline. Only a full-length line that must be compared
	// with a non-empty table starts a search; the first code of the table is stored
	// directly since there is nothing to compare it with.
	always_comb begin
		start_scan = 1'b0;
		dir_store  = 1'b0;
		dir_status = acec_pkg::ST_STOPPED;
		mode_next  = mode_q;
		case (mode_q)
			acec_pkg::MODE_ENROLL: begin
				if (line_len_q == '0 || count_q >= COUNT_FULL) begin
					dir_status = acec_pkg::ST_ENROLL_CLOSED;
					mode_next  = acec_pkg::MODE_CHECK;
				end else if (!all_hex_q) begin
					dir_status = acec_pkg::ST_NOT_HEX;
				end else if (!line_full) begin
					dir_status = acec_pkg::ST_WRONG_LENGTH;
				end else if (count_q == '0) begin
					dir_store  = 1'b1;
					dir_status = acec_pkg::ST_ENROLLED;
				end else begin
					start_scan = 1'b1;
				end
			end
			acec_pkg::MODE_CHECK: begin
				if (line_len_q == '0) begin
					dir_status = acec_pkg::ST_STOPPED;
					mode_next  = acec_pkg::MODE_STOPPED;
				end else if (!line_full || count_q == '0) begin
					dir_status = acec_pkg::ST_WRONG_CODE;
				end else begin
					start_scan = 1'b1;
				end
			end
			default: begin
				dir_status = acec_pkg::ST_STOPPED;
			end
		endcase
	end

	// The search ends at the first matching slot, or after the last stored code.
	assign scan_hit  = (state_q == ST_SCAN) && rd_valid_s1 && (rdata == line_word);
	assign scan_miss = (state_q == ST_SCAN) && rd_valid_s1 && !scan_hit && rd_last_s1;
	assign finish    = scan_hit || scan_miss;

	always_comb begin
		fin_status = acec_pkg::ST_WRONG_CODE;
		fin_slot   = '0;
		if (mode_q == acec_pkg::MODE_ENROLL) begin
			if (scan_hit) begin
				fin_status = acec_pkg::ST_DUPLICATE;
			end else begin
				fin_status = acec_pkg::ST_ENROLLED;
				fin_slot   = count_q;
			end
		end else if (scan_hit) begin
			fin_status = acec_pkg::ST_OPEN;
			fin_slot   = rd_idx_s1;
		end
	end

	// A new code always goes to the slot just past the stored ones.
	assign mem_we     = (nl_acc && dir_store) ||
		(scan_miss && mode_q == acec_pkg::MODE_ENROLL);
	assign count_next = count_q + CW'(mem_we);
	assign res_load   = (nl_acc && !start_scan) || finish;
	assign res_status = finish ? fin_status : dir_status;
	assign res_slot   = finish ? fin_slot : '0;
	assign slot_ext   = {5'b0, res_slot};
	assign count_ext  = {5'b0, count_next};

	acec_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_SLOTS)
	) u_code_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q),
		.wdata (line_word),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// Controller, search pipeline and mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= acec_pkg::MODE_ENROLL;
			count_q     <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
			rd_last_s1  <= 1'b0;
		end else begin
			count_q     <= count_next;
			rd_valid_s1 <= (state_q == ST_SCAN) && issue_q && !finish;
			rd_idx_s1   <= idx_q;
			rd_last_s1  <= (idx_q == last_idx);
			if (nl_acc) begin
				mode_q <= mode_next;
				if (start_scan) begin
					state_q <= ST_SCAN;
					idx_q   <= '0;
					issue_q <= 1'b1;
				end
			end else if (state_q == ST_SCAN) begin
				if (finish) begin
					state_q <= ST_IDLE;
					issue_q <= 1'b0;
				end else if (issue_q) begin
					if (idx_q == last_idx) begin
						issue_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
			end
		end
	end

	// Line length and hex flag; a stopped block ignores ordinary characters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			all_hex_q  <= 1'b1;
		end else if (nl_acc) begin
			line_len_q <= '0;
			all_hex_q  <= 1'b1;
		end else if (char_acc && mode_q != acec_pkg::MODE_STOPPED) begin
			if (!acec_pkg::is_hex(ch)) begin
				all_hex_q <= 1'b0;
			end
			if (line_len_q != LEN_SAT) begin
				line_len_q <= line_len_q + LW'(1);
			end
		end
	end

	// Only the first CODE_CHARS characters of a line are kept.
	always_ff @(posedge clk) begin
		if (char_acc && mode_q != acec_pkg::MODE_STOPPED) begin
			for (int i = 0; i < CODE_CHARS; i++) begin
				if (line_len_q == LW'(i)) begin
					line_chars_q[i] <= ch;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			slot_q   <= slot_ext[4:0];
			stored_q <= count_ext[4:0];
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign matched_slot = slot_q;
	assign stored_count = stored_q;

	`ACEC_ASSERT_ALWAYS(a_count_bound, count_q <= COUNT_FULL, "code count beyond table limit")
	`ACEC_ASSERT_IMP(a_load_free, res_load, !res_valid_q || res_ready, "result overwritten")
	`ACEC_ASSERT_NXT(a_store_count, mem_we, count_q == $past(count_q) + CW'(1), "store lost")
	`ACEC_ASSERT_IMP(a_scan_nonempty, state_q == ST_SCAN, count_q != '0 && !ch_ready, "bad scan")
	`ACEC_ASSERT_NXT(a_stop_sticky, mode_q == acec_pkg::MODE_STOPPED,
		mode_q == acec_pkg::MODE_STOPPED, "left stopped mode")

endmodule

`default_nettype wire
